>>> rtl/ptt_pkg.sv
package ptt_pkg;

  localparam int unsigned TimeW   = 40;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned DueW    = 41;
  localparam int unsigned SlotW   = 4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_HOOK   = 2'd1,
    OP_UNHOOK = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_FIRE      = 3'd0,
    KIND_TICK_DONE = 3'd1,
    KIND_HOOK_OK   = 3'd2,
    KIND_HOOK_REJ  = 3'd3,
    KIND_REMOVED   = 3'd4,
    KIND_NOT_FOUND = 3'd5,
    KIND_CLEARED   = 3'd6
  } kind_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SlotW-1:0]   slot;
    logic [PeriodW-1:0] period_seconds;
    logic [TimeW-1:0]   time_seconds;
  } req_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [SlotW-1:0]   fired_slot;
    logic [TimeW-1:0]   fire_time;
    logic [PeriodW-1:0] fired_period;
    logic [4:0]         fire_count;
    logic               tick_changed;
    logic               last;
  } res_t;

  typedef struct packed {
    op_e                op;
    logic [SlotW-1:0]   slot;
    logic               slot_ok;
    logic               hook_bad;
    logic [PeriodW-1:0] period;
    logic [TimeW-1:0]   now;
  } cmd_t;

endpackage

>>> rtl/ptt_front.sv
module ptt_front #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  ptt_pkg::req_t req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_take_i,
  output ptt_pkg::cmd_t cmd_o
);
  import ptt_pkg::*;

  localparam int unsigned CmpW = (SlotW > 9) ? SlotW : 9;

  cmd_t       buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       do_push, do_pop;

  always_comb begin
    cls.op       = op_e'(req_i.req_type);
    cls.slot     = req_i.slot;
    cls.slot_ok  = CmpW'(req_i.slot) < CmpW'(NUM_SLOTS);
    cls.hook_bad = (req_i.period_seconds == '0) || !cls.slot_ok;
    cls.period   = req_i.period_seconds;
    cls.now      = req_i.time_seconds;
  end

  assign full_o      = cnt_q == 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = buf_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/ptt_rem.sv
module ptt_rem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptt_pkg::TimeW-1:0]     dividend_i,
  input  logic [ptt_pkg::PeriodW-1:0]   divisor_i,
  output logic                          done_o,
  output logic [ptt_pkg::PeriodW-1:0]   rem_o
);
  import ptt_pkg::*;

  logic [PeriodW:0]   r_q, r_shift, r_d;
  logic [TimeW-1:0]   dnd_q;
  logic [PeriodW-1:0] dsr_q;
  logic [5:0]         cnt_q;
  logic               busy_q, done_q;

  always_comb begin
    r_shift = {r_q[PeriodW-1:0], dnd_q[TimeW-1]};
    r_d     = (r_shift >= {1'b0, dsr_q}) ? r_shift - {1'b0, dsr_q} : r_shift;
  end

  assign done_o = done_q;
  assign rem_o  = r_q[PeriodW-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= '0;
      dnd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      r_q   <= r_d;
      dnd_q <= {dnd_q[TimeW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(TimeW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/ptt_back.sv
module ptt_back #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_take_o,
  input  ptt_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output ptt_pkg::res_t res_o
);
  import ptt_pkg::*;

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_FIRE  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [IdxW-1:0]      idx_q, idx_d, cmd_idx, wr_idx;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 changed_q, changed_d;
  logic [TimeW-1:0]     last_q, last_d, now_q, now_d;

  logic [PeriodW-1:0]   mem_per [NUM_SLOTS];
  logic [DueW-1:0]      mem_due [NUM_SLOTS];
  logic [PeriodW-1:0]   rd_per_q;
  logic [DueW-1:0]      rd_due_q;
  logic                 wr_en, wr_hook;
  logic [DueW-1:0]      wr_due;

  logic                 rem_start, rem_done;
  logic [PeriodW-1:0]   rem;
  logic [DueW-1:0]      fire_due;

  ptt_rem u_rem (
    .clk_i,
    .rst_ni,
    .start_i    (rem_start),
    .dividend_i (now_q - rd_due_q[TimeW-1:0]),
    .divisor_i  (rd_per_q),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  assign cmd_idx  = IdxW'(cmd_i.slot);
  assign fire_due = {1'b0, now_q} - DueW'(rem) + DueW'(rd_per_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_due[wr_idx] <= wr_due;
      if (wr_hook) mem_per[wr_idx] <= cmd_i.period;
    end
    rd_per_q <= mem_per[idx_q];
    rd_due_q <= mem_due[idx_q];
  end

  always_comb begin
    state_d       = state_q;
    valid_d       = valid_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    changed_d     = changed_q;
    last_d        = last_q;
    now_d         = now_q;
    cmd_take_o    = 1'b0;
    res_valid_o   = 1'b0;
    res_o         = '0;
    res_o.last    = 1'b1;
    wr_en         = 1'b0;
    wr_hook       = 1'b0;
    wr_idx        = idx_q;
    wr_due        = fire_due;
    rem_start     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_TICK: begin
              cmd_take_o = 1'b1;
              changed_d  = cmd_i.now != last_q;
              last_d     = cmd_i.now;
              now_d      = cmd_i.now;
              idx_d      = '0;
              cnt_d      = '0;
              state_d    = ST_SCAN;
            end
            OP_HOOK: begin
              res_valid_o = 1'b1;
              cmd_take_o  = res_ready_i;
              res_o.kind  = cmd_i.hook_bad ? KIND_HOOK_REJ : KIND_HOOK_OK;
              if (res_ready_i && !cmd_i.hook_bad) begin
                wr_en            = 1'b1;
                wr_hook          = 1'b1;
                wr_idx           = cmd_idx;
                wr_due           = DueW'(cmd_i.now) + DueW'(cmd_i.period);
                valid_d[cmd_idx] = 1'b1;
              end
            end
            OP_UNHOOK: begin
              res_valid_o = 1'b1;
              cmd_take_o  = res_ready_i;
              if (cmd_i.slot_ok && valid_q[cmd_idx]) begin
                res_o.kind = KIND_REMOVED;
                if (res_ready_i) valid_d[cmd_idx] = 1'b0;
              end else begin
                res_o.kind = KIND_NOT_FOUND;
              end
            end
            OP_CLEAR: begin
              res_valid_o = 1'b1;
              cmd_take_o  = res_ready_i;
              res_o.kind  = KIND_CLEARED;
              if (res_ready_i) valid_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (valid_q[idx_q]) begin
          state_d = ST_CHECK;
        end else if (idx_q == IdxW'(NUM_SLOTS - 1)) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_CHECK: begin
        if ({1'b0, now_q} < rd_due_q) begin
          if (idx_q == IdxW'(NUM_SLOTS - 1)) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = ST_SCAN;
          end
        end else begin
          rem_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_done) state_d = ST_FIRE;
      end
      ST_FIRE: begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_FIRE;
        res_o.fired_slot   = SlotW'(idx_q);
        res_o.fire_time    = now_q;
        res_o.fired_period = rd_per_q;
        res_o.last         = 1'b0;
        if (res_ready_i) begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CntW'(1);
          if (idx_q == IdxW'(NUM_SLOTS - 1)) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + IdxW'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_DONE: begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_TICK_DONE;
        res_o.fire_count   = 5'(cnt_q);
        res_o.tick_changed = changed_q;
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      idx_q     <= '0;
      cnt_q     <= '0;
      changed_q <= 1'b0;
      last_q    <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      changed_q <= changed_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d;
  end

endmodule

>>> rtl/ptt_outq.sv
module ptt_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  output logic          res_ready_o,
  input  ptt_pkg::res_t res_i,
  output logic          empty_o,
  input  logic          pop_i,
  output ptt_pkg::res_t res_o
);
  import ptt_pkg::*;

  res_t       buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign res_ready_o = cnt_q != 2'd2;
  assign empty_o     = cnt_q == 2'd0;
  assign res_o       = buf_q[rptr_q];
  assign do_push     = res_valid_i && res_ready_o;
  assign do_pop      = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/periodic_timer_table_unit.sv
// Periodic timer table: NUM_SLOTS interval timers addressed by slot number.
// Requests enter through a queue port (push/full) and results leave through
// a queue port (empty/pop); the oldest result sits on res_o while empty is low.
// Hook, unhook and clear give one result each; with the engine idle, the
// registered request is answered straight into the result queue.
// A tick scans every slot in order and gives one fire result per due slot,
// then a tick-done result carrying the fire count and the changed flag.
// Scan: a free slot is passed in the scan state, an armed slot is checked, and
// a due slot runs the bit-serial remainder unit (one bit per cycle over the
// 40-bit time difference) that computes its due-time catch-up, then fires.
// A two-entry request queue lets new requests land while a tick is scanning;
// a two-entry result queue decouples the engine from the consumer. When pop
// stays low the result queue fills and the engine holds in place, with no
// result lost; full rises once the request queue is also full.
// Reset frees all slots and zeroes the last tick time; both queues come up
// empty. Period and due storage need no clearing.
module periodic_timer_table_unit #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  ptt_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output ptt_pkg::res_t res_o
);
  import ptt_pkg::*;

  logic cmd_valid, cmd_take, res_valid, res_ready;
  cmd_t cmd;
  res_t res;

  ptt_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .full_o      (full),
    .req_i,
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_o       (cmd)
  );

  ptt_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ptt_outq u_outq (
    .clk_i,
    .rst_ni,
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o
  );

endmodule
